// ===== hw/rtl/lgs_pkg.sv =====
// Shared types, constants and the neighbour table of the lattice growth step unit.
`default_nettype none

package lgs_pkg;

  localparam int unsigned IDX_W    = 16;
  localparam int unsigned STATE_W  = 2;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned RAND_W   = 16;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned OPC_W    = 2;

  localparam int unsigned GRID_MAX_SIDE_DEF = 256;

  // Opcodes of an input item.
  localparam logic [OPC_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPC_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OPC_W-1:0] OP_COMMIT = 2'd2;

  // Cell state codes.
  localparam logic [STATE_W-1:0] CELL_EMPTY    = 2'd0;
  localparam logic [STATE_W-1:0] CELL_OCCUPIED = 2'd1;

  // Register indexes of the configuration port.
  localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

  // Lattice memory word: bank a, bank b, weight.
  localparam int unsigned BANK_A_LSB = 0;
  localparam int unsigned BANK_B_LSB = BANK_A_LSB + STATE_W;
  localparam int unsigned WEIGHT_LSB = BANK_B_LSB + STATE_W;
  localparam int unsigned MEM_W      = WEIGHT_LSB + WEIGHT_W;

  // Read slots of one update: the cell itself, then its eight neighbours.
  localparam int unsigned NBR_SLOTS = 9;
  localparam int unsigned SLOT_W    = 4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_DECIDE
  } lgs_state_t;

  typedef enum logic [1:0] {
    OFS_ZERO,
    OFS_NEG,
    OFS_POS
  } ofs_t;

  typedef struct packed {
    ofs_t dr;
    ofs_t dc;
  } nbr_ofs_t;

  // Row and column offset of each read slot.
  function automatic nbr_ofs_t nbr_ofs(input logic [SLOT_W-1:0] slot);
    nbr_ofs_t o;
    o.dr = OFS_ZERO;
    o.dc = OFS_ZERO;
    case (slot)
      4'd1: begin o.dr = OFS_NEG;  o.dc = OFS_NEG;  end
      4'd2: begin o.dr = OFS_NEG;  o.dc = OFS_ZERO; end
      4'd3: begin o.dr = OFS_NEG;  o.dc = OFS_POS;  end
      4'd4: begin o.dr = OFS_ZERO; o.dc = OFS_NEG;  end
      4'd5: begin o.dr = OFS_ZERO; o.dc = OFS_POS;  end
      4'd6: begin o.dr = OFS_POS;  o.dc = OFS_NEG;  end
      4'd7: begin o.dr = OFS_POS;  o.dc = OFS_ZERO; end
      4'd8: begin o.dr = OFS_POS;  o.dc = OFS_POS;  end
      default: begin o.dr = OFS_ZERO; o.dc = OFS_ZERO; end
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lattice_growth_step_unit.sv =====
// Top level of the lattice growth step unit: sequencer, lattice memory and decision logic.
`default_nettype none

// The unit keeps a double-buffered cellular-automaton lattice of up to GRID_MAX_SIDE by
// GRID_MAX_SIDE cells in one single-port synchronous memory whose word holds the cell's state
// in bank a, its state in bank b and its 32-bit Q16.16 suitability weight. An item is taken
// at a clock edge where start is high and busy is low. A load item writes the cell in that
// same cycle and a commit item swaps the current and next bank in that cycle; neither gives
// a result. An update item keeps busy high from the edge that takes it through the divider
// stage (eight two-bit steps that find the cell's row and column, then taking them over),
// the read state, which reads the cell and its eight neighbours one per cycle through the
// memory port, and the decide state, which decides and writes the next bank. Its result is
// registered from the decide state and appears on out_valid, out_result_index and
// out_new_state for exactly one cycle; the receiver cannot stall it. Update items at an
// index outside the grid, and opcode three, are dropped without a result. After reset the
// unit sweeps all GRID_MAX_SIDE squared memory entries to all-empty, zero-weight words, one
// entry per cycle; busy stays high throughout, while configuration writes are taken as
// usual. The grid width and height registers are saturated to the range 3 to GRID_MAX_SIDE
// where they are used; the user must only change them while the unit is idle, as the unit
// itself does not enforce this.
module lattice_growth_step_unit #(
  parameter int unsigned GRID_MAX_SIDE = lgs_pkg::GRID_MAX_SIDE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [lgs_pkg::OPC_W-1:0]    in_opcode,
  input  logic [lgs_pkg::IDX_W-1:0]    in_cell_index,
  input  logic [lgs_pkg::STATE_W-1:0]  in_cell_state,
  input  logic [lgs_pkg::WEIGHT_W-1:0] in_cell_weight,
  input  logic [lgs_pkg::RAND_W-1:0]   in_random_value,
  output logic                         out_valid,
  output logic [lgs_pkg::IDX_W-1:0]    out_result_index,
  output logic [lgs_pkg::STATE_W-1:0]  out_new_state,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [lgs_pkg::CFG_W-1:0]    cfg_wdata
);
  import lgs_pkg::*;

  localparam int unsigned SW      = $clog2(GRID_MAX_SIDE + 1);
  localparam int unsigned SLOTS   = GRID_MAX_SIDE * GRID_MAX_SIDE;
  localparam int unsigned AW      = $clog2(SLOTS);
  localparam int unsigned CELLS_W = 2 * SW;
  localparam int unsigned SUM_W   = WEIGHT_W + 3;
  localparam int unsigned PROD_W  = SUM_W + 16;

  // Saturate a side register to the supported range.
  function automatic logic [SW-1:0] side_clamp(input logic [CFG_W-1:0] v);
    if (32'(v) < 32'd3) begin
      return SW'(3);
    end else if (32'(v) > 32'(GRID_MAX_SIDE)) begin
      return SW'(GRID_MAX_SIDE);
    end else begin
      return SW'(v);
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------------------
  logic [CFG_W-1:0]   cfg_width_r;
  logic [CFG_W-1:0]   cfg_height_r;
  logic [SW-1:0]      grid_w;
  logic [SW-1:0]      grid_h;
  logic [CELLS_W-1:0] cells;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CFG_W'(256);
      cfg_height_r <= CFG_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  cfg_width_r  <= cfg_wdata;
        REG_GRID_HEIGHT: cfg_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign grid_w = side_clamp(cfg_width_r);
  assign grid_h = side_clamp(cfg_height_r);
  assign cells  = CELLS_W'(grid_w) * CELLS_W'(grid_h);

  // ---------------------------------------------------------------------------------------
  // Sequencer state and handshake
  // ---------------------------------------------------------------------------------------
  lgs_state_t state_r;
  lgs_state_t state_nxt;

  logic accept;
  logic idx_in_grid;
  logic div_start;
  logic div_done;
  logic [IDX_W-1:0] div_quo;
  logic [SW-1:0]    div_rem;

  logic [AW-1:0]     clr_addr_r;
  logic              clr_last;
  logic [SLOT_W-1:0] slot_r;
  logic              slot_end;

  assign accept      = start && !busy;
  assign idx_in_grid = 32'(in_cell_index) < 32'(cells);
  assign div_start   = accept && (in_opcode == OP_UPDATE) && idx_in_grid;
  assign clr_last    = 32'(clr_addr_r) == 32'(SLOTS - 1);
  assign slot_end    = slot_r == SLOT_W'(NBR_SLOTS);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_last)  state_nxt = ST_IDLE;
      ST_IDLE:   if (div_start) state_nxt = ST_DIV;
      ST_DIV:    if (div_done)  state_nxt = ST_READ;
      ST_READ:   if (slot_end)  state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The divider turns the flat index into row (quotient) and column (remainder).
  lgs_divider #(
    .DIV_W (SW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_cell_index),
    .divisor   (grid_w),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // ---------------------------------------------------------------------------------------
  // Item registers and neighbour addressing
  // ---------------------------------------------------------------------------------------
  logic              current_bank_r;
  logic [IDX_W-1:0]  idx_r;
  logic [RAND_W-1:0] rnd_r;
  logic              row_lo_ok_r;
  logic              row_hi_ok_r;
  logic              col_lo_ok_r;
  logic              col_hi_ok_r;

  logic [AW-1:0] idx_a;
  logic [AW-1:0] w_a;
  logic [AW-1:0] row_base;
  logic [AW-1:0] nbr_addr;
  logic          nbr_ok;
  nbr_ofs_t      ofs;

  assign idx_a = AW'(idx_r);
  assign w_a   = AW'(grid_w);

  // A neighbour off the grid is still read, but its word is ignored.
  always_comb begin
    ofs      = nbr_ofs(slot_r);
    row_base = idx_a;
    nbr_addr = idx_a;
    nbr_ok   = 1'b1;
    case (ofs.dr)
      OFS_NEG: begin row_base = idx_a - w_a; nbr_ok = row_lo_ok_r; end
      OFS_POS: begin row_base = idx_a + w_a; nbr_ok = row_hi_ok_r; end
      default: row_base = idx_a;
    endcase
    case (ofs.dc)
      OFS_NEG: begin nbr_addr = row_base - AW'(1); nbr_ok = nbr_ok && col_lo_ok_r; end
      OFS_POS: begin nbr_addr = row_base + AW'(1); nbr_ok = nbr_ok && col_hi_ok_r; end
      default: nbr_addr = row_base;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Lattice memory: one port, read data registered
  // ---------------------------------------------------------------------------------------
  logic [MEM_W-1:0] mem [SLOTS];
  logic [MEM_W-1:0] rd_data_r;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [MEM_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  // ---------------------------------------------------------------------------------------
  // Read accumulation and decision
  // ---------------------------------------------------------------------------------------
  logic                rd_pend_r;
  logic [SLOT_W-1:0]   rd_slot_r;
  logic                rd_ok_r;
  logic [MEM_W-1:0]    center_word_r;
  logic [STATE_W-1:0]  here_r;
  logic [SUM_W-1:0]    sum_r;
  logic [STATE_W-1:0]  rd_state;
  logic [PROD_W-1:0]   lhs;
  logic [PROD_W-1:0]   rhs;
  logic                occupy;
  logic [STATE_W-1:0]  new_state;
  logic [MEM_W-1:0]    wb_word;

  logic                out_valid_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic [STATE_W-1:0]  out_state_r;

  // State of the word just read, as seen in the current bank.
  assign rd_state = current_bank_r ? rd_data_r[BANK_B_LSB +: STATE_W]
                                   : rd_data_r[BANK_A_LSB +: STATE_W];

  // Occupy an empty cell if rnd/65535 < sum/2^19, i.e. rnd*2^19 < sum*65535, exactly.
  always_comb begin
    lhs       = PROD_W'({rnd_r, 19'b0});
    rhs       = PROD_W'({sum_r, 16'b0}) - PROD_W'(sum_r);
    occupy    = (here_r == CELL_EMPTY) && (lhs < rhs);
    new_state = occupy ? CELL_OCCUPIED : here_r;
    wb_word   = center_word_r;
    if (current_bank_r) begin
      wb_word[BANK_A_LSB +: STATE_W] = new_state;
    end else begin
      wb_word[BANK_B_LSB +: STATE_W] = new_state;
    end
  end

  // Memory port selection and the busy flag follow the sequencer state. In the idle state
  // busy is low, so start alone marks an accepted item there.
  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_addr  = idx_a;
    mem_wdata = wb_word;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        busy      = 1'b0;
        mem_we    = start && (in_opcode == OP_LOAD) && idx_in_grid;
        mem_addr  = AW'(in_cell_index);
        mem_wdata = {in_cell_weight, in_cell_state, in_cell_state};
      end
      ST_READ: begin
        mem_addr = nbr_addr;
      end
      ST_DECIDE: begin
        mem_we    = 1'b1;
        mem_addr  = idx_a;
        mem_wdata = wb_word;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_bank_r <= 1'b0;
      clr_addr_r     <= '0;
      slot_r         <= '0;
      rd_pend_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= state_r == ST_DECIDE;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (accept && (in_opcode == OP_COMMIT)) begin
        current_bank_r <= ~current_bank_r;
      end
      if (state_r == ST_DIV) begin
        slot_r    <= '0;
        rd_pend_r <= 1'b0;
      end else if (state_r == ST_READ) begin
        rd_pend_r <= !slot_end;
        if (!slot_end) begin
          slot_r <= slot_r + SLOT_W'(1);
        end
      end else begin
        rd_pend_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (div_start) begin
      idx_r <= in_cell_index;
      rnd_r <= in_random_value;
    end
    if ((state_r == ST_DIV) && div_done) begin
      row_lo_ok_r <= div_quo != '0;
      row_hi_ok_r <= (32'(div_quo) + 32'd1) < 32'(grid_h);
      col_lo_ok_r <= div_rem != '0;
      col_hi_ok_r <= (32'(div_rem) + 32'd1) < 32'(grid_w);
      sum_r       <= '0;
    end
    if (state_r == ST_READ) begin
      rd_slot_r <= slot_r;
      rd_ok_r   <= nbr_ok;
      if (rd_pend_r && rd_ok_r) begin
        if (rd_slot_r == '0) begin
          center_word_r <= rd_data_r;
          here_r        <= rd_state;
        end else if (rd_state == CELL_OCCUPIED) begin
          sum_r <= sum_r + SUM_W'(rd_data_r[WEIGHT_LSB +: WEIGHT_W]);
        end
      end
    end
    if (state_r == ST_DECIDE) begin
      out_idx_r   <= idx_r;
      out_state_r <= new_state;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_new_state    = out_state_r;

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  a_result_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_DECIDE))
    else $error("result strobe without a decide cycle");

  a_result_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_result_index) < 32'(cells)))
    else $error("result index outside the grid");

  a_bank_swap_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (current_bank_r != $past(current_bank_r)))
      |-> $past(start && !busy && (in_opcode == OP_COMMIT)))
    else $error("bank swapped without a commit item");

  a_read_after_divide: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_READ) && $past(state_r == ST_DIV)) |-> $past(div_done))
    else $error("neighbour reads started before the divider finished");

endmodule

`default_nettype wire

// ===== hw/rtl/lgs_divider.sv =====
// Radix-4 restoring divider that splits a flat cell index into row and column.
`default_nettype none

module lgs_divider #(
  parameter int unsigned DIV_W = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lgs_pkg::IDX_W-1:0] dividend,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      done,
  output logic [lgs_pkg::IDX_W-1:0] quotient,
  output logic [DIV_W-1:0]          remainder
);
  import lgs_pkg::*;

  localparam int unsigned STEPS = IDX_W / 2;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic             run_r;
  logic             done_r;
  logic             done_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] div_r;
  logic [IDX_W-1:0] quo_r;

  logic [DIV_W:0]   part1;
  logic [DIV_W:0]   part2;
  logic             ge1;
  logic             ge2;
  logic [DIV_W-1:0] rem1;
  logic [DIV_W-1:0] rem_nxt;
  logic [IDX_W-1:0] quo_nxt;

  // Two quotient bits per cycle; quo_r shifts dividend bits out and quotient bits in.
  always_comb begin
    part1   = {rem_r, quo_r[IDX_W-1]};
    ge1     = part1 >= {1'b0, div_r};
    rem1    = ge1 ? DIV_W'(part1 - {1'b0, div_r}) : DIV_W'(part1);
    part2   = {rem1, quo_r[IDX_W-2]};
    ge2     = part2 >= {1'b0, div_r};
    rem_nxt = ge2 ? DIV_W'(part2 - {1'b0, div_r}) : DIV_W'(part2);
    quo_nxt = {quo_r[IDX_W-3:0], ge1, ge2};
  end

  assign done_nxt = run_r && (cnt_r == CNT_W'(STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= done_nxt;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (done_nxt) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire
